// File: rtl/gnms_pkg.sv
// ----------------------------------------------------------------------------
// gnms_pkg: shared types and constants for the NMS box filter
// Field widths, the controller/datapath command struct and the status struct.
// ----------------------------------------------------------------------------
package gnms_pkg;

    localparam int COORD_W = 16;
    localparam int SCORE_W = 16;
    localparam int CLASS_W = 2;
    localparam int THR_W   = 9;
    localparam logic [THR_W-1:0] THR_RESET = 9'd128;
    localparam logic [THR_W-1:0] THR_OFF   = 9'd256;
    localparam logic [1:0] REG_IOU_THRESHOLD = 2'd0;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [SCORE_W-1:0] score;
        logic [CLASS_W-1:0] cls;
    } box_t;

    // Controller to datapath.
    typedef struct packed {
        logic store;      // write incoming box at count
        logic clear;      // clear count and overflow
        logic sort_rd;    // read the box just above the insertion point
        logic sort_step;  // one insertion-sort compare/move step
        logic sort_init;  // load box i as the insertion key
        logic rd_a;       // read box a (outer) at order index
        logic rd_b;       // read box b (inner)
        logic iou_eval;   // register intersection and union of latched a and b
        logic emit_rd;    // read box at emit index
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic full;
        logic ins_done;
        logic suppress;
    } dp_stat_t;

endpackage

// File: rtl/gnms_ctrl.sv
// ----------------------------------------------------------------------------
// gnms_ctrl: batch controller
// Sequences loading, insertion sort, pairwise suppression and emission.
// ----------------------------------------------------------------------------
module gnms_ctrl
    import gnms_pkg::*;
#(
    parameter int MAX_BOXES = 64,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    input  logic [CNT_W-1:0]  count,
    input  logic [THR_W-1:0]  thr,
    input  dp_stat_t          stat,
    input  logic [MAX_BOXES-1:0] supp,
    output dp_cmd_t           cmd,
    output logic [IDX_W-1:0]  idx_i,
    output logic [IDX_W-1:0]  idx_j,
    output logic              set_supp,
    output logic              init_supp,
    output logic              out_load,
    output logic              out_none,
    output logic              out_final,
    input  logic              out_free
);

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_SINIT = 11'b00000000010,
        S_SRD   = 11'b00000000100,
        S_SORT  = 11'b00000001000,
        S_OUTER = 11'b00000010000,
        S_RDB   = 11'b00000100000,
        S_EVAL  = 11'b00001000000,
        S_TEST  = 11'b00010000000,
        S_EMIT  = 11'b00100000000,
        S_EOUT  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next;
    logic any_reg, any_next;

    assign idx_i = i_reg[IDX_W-1:0];
    assign idx_j = j_reg[IDX_W-1:0];
    assign in_ready = (state_reg == S_LOAD);

    always_comb begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        any_next = any_reg;
        cmd = '0;
        set_supp = 1'b0;
        init_supp = 1'b0;
        out_load = 1'b0;
        out_none = 1'b0;
        out_final = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                if (in_valid) begin
                    cmd.store = 1'b1;
                    if (in_last) begin
                        state_next = S_SINIT;
                        i_next = '0;
                    end
                end
            end
            S_SINIT: begin
                // Count has been updated; insert element i into the sorted prefix.
                if (i_reg == count) begin
                    init_supp = 1'b1;
                    i_next = '0;
                    any_next = 1'b0;
                    state_next = (thr >= THR_OFF) ? S_EMIT : S_OUTER;
                end else begin
                    cmd.sort_init = 1'b1;
                    state_next = S_SRD;
                end
            end
            S_SRD: begin
                cmd.sort_rd = 1'b1;
                state_next = S_SORT;
            end
            S_SORT: begin
                cmd.sort_step = 1'b1;
                if (stat.ins_done) begin
                    i_next = i_reg + 1'b1;
                    state_next = S_SINIT;
                end else begin
                    state_next = S_SRD;
                end
            end
            S_OUTER: begin
                if (i_reg >= count) begin
                    i_next = '0;
                    state_next = S_EMIT;
                end else if (supp[idx_i]) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    cmd.rd_a = 1'b1;
                    j_next = i_reg + 1'b1;
                    state_next = S_RDB;
                end
            end
            S_RDB: begin
                if (j_reg >= count) begin
                    i_next = i_reg + 1'b1;
                    state_next = S_OUTER;
                end else if (supp[idx_j]) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    cmd.rd_b = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.iou_eval = 1'b1;
                state_next = S_TEST;
            end
            S_TEST: begin
                if (stat.suppress) set_supp = 1'b1;
                j_next = j_reg + 1'b1;
                state_next = S_RDB;
            end
            S_EMIT: begin
                if (i_reg >= count) begin
                    if (!any_reg && out_free) begin
                        out_load = 1'b1;
                        out_none = 1'b1;
                        out_final = 1'b1;
                        state_next = S_DONE;
                    end else if (any_reg) begin
                        state_next = S_DONE;
                    end
                end else if (supp[idx_i]) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    cmd.emit_rd = 1'b1;
                    state_next = S_EOUT;
                end
            end
            S_EOUT: begin
                // Look ahead for another survivor to decide the final flag.
                if (out_free) begin
                    out_load = 1'b1;
                    out_final = 1'b1;
                    for (int k = 0; k < MAX_BOXES; k++) begin
                        if (k > int'(i_reg) && k < int'(count) && !supp[k]) out_final = 1'b0;
                    end
                    any_next = 1'b1;
                    i_next = i_reg + 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_DONE: begin
                cmd.clear = 1'b1;
                state_next = S_LOAD;
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            i_reg <= '0;
            j_reg <= '0;
            any_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
            any_reg <= any_next;
        end
    end

endmodule

// File: rtl/gnms_dp.sv
// ----------------------------------------------------------------------------
// gnms_dp: box storage, sort order and overlap arithmetic
// Holds the box memory, sorted in place by score, and the IoU test.
// ----------------------------------------------------------------------------
module gnms_dp
    import gnms_pkg::*;
#(
    parameter int MAX_BOXES = 64,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    input  box_t              in_box,
    input  logic [IDX_W-1:0]  idx_i,
    input  logic [IDX_W-1:0]  idx_j,
    input  logic              set_supp,
    input  logic              init_supp,
    input  logic [THR_W-1:0]  thr,
    output logic [CNT_W-1:0]  count,
    output logic              ovf,
    output dp_stat_t          stat,
    output logic [MAX_BOXES-1:0] supp,
    output box_t              rd_box
);

    box_t mem [MAX_BOXES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] nz_reg;
    logic ovf_reg;
    logic [MAX_BOXES-1:0] supp_reg;
    logic [CNT_W-1:0] k_reg;
    box_t key_reg, prev_reg;
    box_t a_reg, b_reg;
    logic [37:0] inter_reg;
    logic [38:0] uni_reg;
    logic [IDX_W-1:0] rd_addr;
    logic suppress;

    assign count = count_reg;
    assign ovf = ovf_reg;
    assign supp = supp_reg;
    assign rd_box = a_reg;

    wire full = (count_reg == CNT_W'(MAX_BOXES));
    wire [IDX_W-1:0] km1 = IDX_W'(k_reg - 1'b1);
    wire ins_done = (k_reg == '0) || !(prev_reg.score < key_reg.score);
    assign stat = '{full: full, ins_done: ins_done, suppress: suppress};

    // One read address per cycle; the command picks where the word lands.
    assign rd_addr = cmd.sort_rd ? km1 : (cmd.rd_b ? idx_j : idx_i);

    // Boxes are sorted in place: the key walks down while lower scores move up.
    always_ff @(posedge aclk) begin
        if (cmd.store && !full) begin
            mem[count_reg[IDX_W-1:0]] <= in_box;
        end else if (cmd.sort_step) begin
            mem[k_reg[IDX_W-1:0]] <= ins_done ? key_reg : prev_reg;
        end
        if (cmd.sort_init) begin
            k_reg <= CNT_W'(idx_i);
            key_reg <= mem[rd_addr];
        end
        if (cmd.sort_step && !ins_done) k_reg <= k_reg - 1'b1;
        if (cmd.sort_rd) prev_reg <= mem[rd_addr];
        if (cmd.rd_a || cmd.emit_rd) a_reg <= mem[rd_addr];
        if (cmd.rd_b) b_reg <= mem[rd_addr];
    end

    // Doubled-coordinate overlap test: intersection and union are registered,
    // then compared against the threshold in the following cycle.
    logic signed [18:0] al, ar, at, ab, bl, br, bt, bb;
    logic signed [19:0] iw, ih;
    logic [18:0] iwu, ihu;
    logic [37:0] inter;
    logic [35:0] area_a, area_b;
    logic [47:0] lhs, rhs;
    logic [38:0] uni;
    always_comb begin
        al = 19'(2 * $signed({3'b0, a_reg.x}) - $signed({3'b0, a_reg.w}));
        ar = 19'(2 * $signed({3'b0, a_reg.x}) + $signed({3'b0, a_reg.w}));
        at = 19'(2 * $signed({3'b0, a_reg.y}) - $signed({3'b0, a_reg.h}));
        ab = 19'(2 * $signed({3'b0, a_reg.y}) + $signed({3'b0, a_reg.h}));
        bl = 19'(2 * $signed({3'b0, b_reg.x}) - $signed({3'b0, b_reg.w}));
        br = 19'(2 * $signed({3'b0, b_reg.x}) + $signed({3'b0, b_reg.w}));
        bt = 19'(2 * $signed({3'b0, b_reg.y}) - $signed({3'b0, b_reg.h}));
        bb = 19'(2 * $signed({3'b0, b_reg.y}) + $signed({3'b0, b_reg.h}));
        iw = 20'((ar < br ? ar : br)) - 20'((al > bl ? al : bl));
        ih = 20'((ab < bb ? ab : bb)) - 20'((at > bt ? at : bt));
        iwu = iw[19] ? '0 : iw[18:0];
        ihu = ih[19] ? '0 : ih[18:0];
        inter = 38'(iwu) * 38'(ihu);
        area_a = 36'({a_reg.w, 1'b0}) * 36'({a_reg.h, 1'b0});
        area_b = 36'({b_reg.w, 1'b0}) * 36'({b_reg.h, 1'b0});
        uni = 39'(area_a) + 39'(area_b) - 39'(inter);
        lhs = 48'({inter_reg, 8'b0});
        rhs = 48'(uni_reg) * 48'(thr);
        suppress = (uni_reg != '0) && (lhs >= rhs);
    end

    always_ff @(posedge aclk) begin
        if (cmd.iou_eval) begin
            inter_reg <= inter;
            uni_reg <= uni;
        end
    end

    // Zero scores sort to the tail, so they occupy the positions from nz up.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            nz_reg <= '0;
            ovf_reg <= 1'b0;
            supp_reg <= '0;
        end else begin
            if (cmd.clear) begin
                count_reg <= '0;
                nz_reg <= '0;
                ovf_reg <= 1'b0;
                supp_reg <= '0;
            end else if (cmd.store) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + 1'b1;
                    if (in_box.score != '0) nz_reg <= nz_reg + 1'b1;
                end
            end
            if (init_supp) begin
                for (int k = 0; k < MAX_BOXES; k++)
                    supp_reg[k] <= (k >= int'(nz_reg));
            end
            if (set_supp) supp_reg[idx_j] <= 1'b1;
        end
    end

endmodule

// File: rtl/greedy_nms_box_filter_core.sv
// Operation: a batch of n boxes loads at one word per cycle, then is sorted
// by insertion, each kept box is tested for overlap against the lower-ranked
// boxes still standing, and the surviving boxes are emitted in score order.
// Throughput: one batch at a time; a new batch is accepted after the last
// result of the previous one. Reset (synchronous, active low) clears the
// count, flags and threshold (to 128); the box memory needs no clearing.
// ----------------------------------------------------------------------------
// greedy_nms_box_filter_core: greedy non-maximum suppression of detections
// Stores a batch, orders it by score and emits the boxes that survive IoU.
// ----------------------------------------------------------------------------
module greedy_nms_box_filter_core
    import gnms_pkg::*;
#(
    parameter int MAX_BOXES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // center_x, center_y, box_width, box_height, score, class_id, zero pad
    input  logic [87:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kept_x, kept_y, kept_width, kept_height, kept_score, kept_class, pad
    output logic [87:0] m_tdata,
    output logic        m_tlast,
    // none_kept, overflowed
    output logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    logic [THR_W-1:0] thr_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == {REG_IOU_THRESHOLD[1:0]}) ? {23'b0, thr_reg} : 32'b0;
    always_ff @(posedge aclk) begin
        if (!aresetn) thr_reg <= THR_RESET;
        else if (psel && penable && pwrite && paddr == {REG_IOU_THRESHOLD[1:0]})
            thr_reg <= pwdata[THR_W-1:0];
    end

    box_t in_box;
    assign in_box = '{x: s_tdata[15:0], y: s_tdata[31:16], w: s_tdata[47:32],
                      h: s_tdata[63:48], score: s_tdata[79:64], cls: s_tdata[81:80]};

    dp_cmd_t cmd;
    dp_stat_t stat;
    logic [CNT_W-1:0] count;
    logic ovf, set_supp, init_supp, out_load, out_none, out_final;
    logic [MAX_BOXES-1:0] supp;
    logic [IDX_W-1:0] idx_i, idx_j;
    box_t rd_box;
    logic [THR_W-1:0] thr_eff;
    assign thr_eff = (thr_reg > THR_OFF) ? THR_OFF : thr_reg;

    logic m_valid_reg;
    logic [87:0] m_data_reg;
    logic m_last_reg;
    logic [1:0] m_user_reg;
    wire out_free = !m_valid_reg || m_tready;

    gnms_ctrl #(.MAX_BOXES(MAX_BOXES), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_last(s_tlast), .in_ready(s_tready),
        .count, .thr(thr_eff), .stat, .supp, .cmd, .idx_i, .idx_j, .set_supp,
        .init_supp, .out_load, .out_none, .out_final, .out_free
    );

    gnms_dp #(.MAX_BOXES(MAX_BOXES), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_dp (
        .aclk, .aresetn, .cmd, .in_box, .idx_i, .idx_j, .set_supp, .init_supp,
        .thr(thr_eff), .count, .ovf, .stat, .supp, .rd_box
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_data_reg <= out_none ? 88'b0 :
                {6'b0, rd_box.cls, rd_box.score, rd_box.h, rd_box.w, rd_box.y, rd_box.x};
            m_last_reg <= out_final;
            m_user_reg <= {ovf, out_none};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tlast = m_last_reg;
    assign m_tuser = m_user_reg;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the greedy NMS box filter core
// Sends batches of detection boxes, predicts the surviving boxes with a
// score-ordered greedy overlap filter of its own, and compares every result
// word field by field under varied threshold settings and handshake idling.
// ----------------------------------------------------------------------------
module tb;
    import gnms_pkg::*;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] score;
        logic [1:0]  cls;
        logic        final_r;
        logic        none;
        logic        ovf;
    } kept_t;

    localparam int CAPACITY = 64;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    greedy_nms_box_filter_core #(.MAX_BOXES(CAPACITY)) dut (.*);

    // Predictor state.
    box_t        batch_boxes[CAPACITY];
    int          batch_len;
    bit          batch_ovf;
    int unsigned threshold;

    kept_t expected_kept[$];
    int    errors;
    int    results_seen;
    int    batches_sent;
    int    boxes_sent;
    int    send_idle_pct;
    int    recv_stall_pct;
    bit    hold_off;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic bit boxes_overlap(box_t a, box_t b, int unsigned thr);
        longint al, ar, at, ab, bl, br, bt, bb, iw, ih, inter, uni;
        al = 2 * longint'(a.x) - a.w;
        ar = 2 * longint'(a.x) + a.w;
        at = 2 * longint'(a.y) - a.h;
        ab = 2 * longint'(a.y) + a.h;
        bl = 2 * longint'(b.x) - b.w;
        br = 2 * longint'(b.x) + b.w;
        bt = 2 * longint'(b.y) - b.h;
        bb = 2 * longint'(b.y) + b.h;
        iw = ((ar < br) ? ar : br) - ((al > bl) ? al : bl);
        ih = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt);
        if (iw < 0) iw = 0;
        if (ih < 0) ih = 0;
        inter = iw * ih;
        uni = (2 * longint'(a.w)) * (2 * longint'(a.h)) +
              (2 * longint'(b.w)) * (2 * longint'(b.h)) - inter;
        if (uni <= 0) return 1'b0;
        return 256 * inter >= longint'(thr) * uni;
    endfunction

    // Stores a box and, when the batch closes, queues the surviving boxes.
    task automatic predict_survivors(box_t b, bit last);
        int    order[CAPACITY];
        bit    gone[CAPACITY];
        int    k;
        int    n_kept;
        kept_t r;
        if (batch_len < CAPACITY) begin
            batch_boxes[batch_len] = b;
            batch_len++;
        end else begin
            batch_ovf = 1'b1;
        end
        if (!last) return;
        for (int i = 0; i < batch_len; i++) begin
            k = i;
            while (k > 0 && batch_boxes[order[k-1]].score < batch_boxes[i].score) begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = i;
        end
        for (int i = 0; i < batch_len; i++) gone[i] = (batch_boxes[i].score == 0);
        if (threshold < 256) begin
            for (int i = 0; i < batch_len; i++) begin
                if (gone[order[i]]) continue;
                for (int j = i + 1; j < batch_len; j++) begin
                    if (!gone[order[j]] &&
                        boxes_overlap(batch_boxes[order[i]], batch_boxes[order[j]], threshold))
                        gone[order[j]] = 1'b1;
                end
            end
        end
        n_kept = 0;
        for (int i = 0; i < batch_len; i++) begin
            if (gone[order[i]]) continue;
            r = '0;
            r.x = batch_boxes[order[i]].x;
            r.y = batch_boxes[order[i]].y;
            r.w = batch_boxes[order[i]].w;
            r.h = batch_boxes[order[i]].h;
            r.score = batch_boxes[order[i]].score;
            r.cls = batch_boxes[order[i]].cls;
            r.ovf = batch_ovf;
            expected_kept = {expected_kept, r};
            n_kept++;
        end
        if (n_kept == 0) begin
            r = '0;
            r.final_r = 1'b1;
            r.none = 1'b1;
            r.ovf = batch_ovf;
            expected_kept = {expected_kept, r};
        end else begin
            expected_kept[$].final_r = 1'b1;
        end
        batch_len = 0;
        batch_ovf = 1'b0;
        batches_sent++;
    endtask

    // The word stays valid after acceptance until the next idle cycle or pause.
    task automatic send_box(box_t b, bit last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, b.cls, b.score, b.h, b.w, b.y, b.x};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_survivors(b, last);
        boxes_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_kept.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_threshold(int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_IOU_THRESHOLD;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        threshold = value & 9'h1FF;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (prdata[8:0] !== threshold[8:0]) begin
            $display("%0t threshold readback: expected %0d actual %0d",
                     $time, threshold, prdata[8:0]);
            errors++;
        end
    endtask

    function automatic box_t make_box(int unsigned cx, int unsigned cy, int unsigned w,
                                      int unsigned h, int unsigned s, int unsigned c);
        box_t b;
        b.x = 16'(cx);
        b.y = 16'(cy);
        b.w = 16'(w);
        b.h = 16'(h);
        b.score = 16'(s);
        b.cls = 2'(c);
        return b;
    endfunction

    // Boxes clustered in a small area so that overlaps are common.
    function automatic box_t clustered_box();
        box_t b;
        b.x = 16'(800 + $urandom_range(400));
        b.y = 16'(800 + $urandom_range(400));
        b.w = 16'($urandom_range(600, 1));
        b.h = 16'($urandom_range(600, 1));
        b.score = ($urandom_range(9) == 0) ? 16'd0 :
                  (($urandom_range(4) == 0) ? 16'(1000 * $urandom_range(3)) :
                   16'($urandom));
        b.cls = 2'($urandom);
        return b;
    endfunction

    function automatic box_t noise_box();
        box_t b;
        b.x = 16'($urandom);
        b.y = 16'($urandom);
        b.w = 16'($urandom);
        b.h = 16'($urandom);
        b.score = 16'($urandom);
        b.cls = 2'($urandom);
        return b;
    endfunction

    task automatic send_random_batch(int unsigned n);
        for (int i = 0; i < n; i++)
            send_box(($urandom_range(3) == 0) ? noise_box() : clustered_box(), i == n - 1);
    endtask

    task automatic test_directed();
        // Equal scores keep arrival order; the second box overlaps the first fully.
        send_box(make_box(1000, 1000, 200, 200, 500, 1), 1'b0);
        send_box(make_box(1000, 1000, 200, 200, 500, 2), 1'b0);
        send_box(make_box(5000, 5000, 100, 100, 900, 3), 1'b0);
        send_box(make_box(100, 100, 10, 10, 0, 0), 1'b1);
        // Extremes of the geometry fields and full scores.
        send_box(make_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3), 1'b0);
        send_box(make_box(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 1'b0);
        send_box(make_box(0, 0, 0, 0, 1, 2), 1'b1);
        // Two zero-area boxes at one point: the union is zero, so both survive.
        send_box(make_box(300, 300, 0, 0, 700, 1), 1'b0);
        send_box(make_box(300, 300, 0, 0, 600, 2), 1'b1);
        // Every box scored zero gives the empty result.
        send_box(make_box(10, 10, 10, 10, 0, 3), 1'b0);
        send_box(make_box(20, 20, 10, 10, 0, 1), 1'b1);
        // Single-box batch.
        send_box(make_box(1234, 4321, 55, 66, 16'h8000, 2), 1'b1);
        wait_drained();
    endtask

    task automatic test_thresholds();
        int unsigned settings[6] = '{0, 1, 256, 511, 255, 64};
        foreach (settings[i]) begin
            write_threshold(settings[i]);
            repeat (5) send_random_batch($urandom_range(8, 2));
            wait_drained();
        end
        write_threshold(128);
    endtask

    task automatic test_overflow();
        // One more box than the capacity, the extra one closing the batch.
        for (int i = 0; i <= CAPACITY; i++)
            send_box(clustered_box(), i == CAPACITY);
        for (int i = 0; i < CAPACITY + 3; i++)
            send_box(noise_box(), i == CAPACITY + 2);
        wait_drained();
    endtask

    task automatic test_idling();
        int pcts[4][2] = '{'{0, 0}, '{74, 0}, '{0, 74}, '{29, 29}};
        int stop;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = pcts[p][0];
            recv_stall_pct = pcts[p][1];
            stop = boxes_sent + 14;
            while (boxes_sent < stop)
                send_random_batch($urandom_range(10, 1));
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        repeat (4) send_random_batch($urandom_range(6, 3));
        wait_drained();
    endtask

    // Long receiver hold-off, counted on its own.
    always begin
        wait (hold_off);
        repeat (3000) @(posedge aclk);
        hold_off = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        kept_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[15:0];
            got.y = m_tdata[31:16];
            got.w = m_tdata[47:32];
            got.h = m_tdata[63:48];
            got.score = m_tdata[79:64];
            got.cls = m_tdata[81:80];
            got.final_r = m_tlast;
            got.none = m_tuser[0];
            got.ovf = m_tuser[1];
            results_seen++;
            if (expected_kept.size() == 0) begin
                $display("%0t unexpected result word: expected none actual %h", $time, got);
                errors++;
            end else begin
                want = expected_kept.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
                    got.h !== want.h || got.score !== want.score || got.cls !== want.cls ||
                    got.final_r !== want.final_r || got.none !== want.none ||
                    got.ovf !== want.ovf) begin
                    $display("%0t result mismatch: expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors = 0;
        results_seen = 0;
        batches_sent = 0;
        boxes_sent = 0;
        batch_len = 0;
        batch_ovf = 1'b0;
        threshold = 128;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_thresholds();
        test_overflow();
        test_backpressure();
        test_idling();
        $display("Covered %0d boxes in %0d batches, %0d result words checked,",
                 boxes_sent, batches_sent, results_seen);
        $display("across thresholds 0 to 511, capacity overflow and four idling mixes.");
        if (errors == 0 && expected_kept.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d errors, %0d results still pending", errors, expected_kept.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Timed out with %0d results pending", expected_kept.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
